### hdl/contiguous_page_bitmap_allocator_macros.svh
// ============================================================================
// Contiguous page bitmap allocator: assertion macros
// Shared shorthand for the concurrent checks on the allocator ports.
// ============================================================================
`ifndef CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_BITMAP_ALLOCATOR_MACROS_SVH

// Consequent must hold in the clock after the antecedent.
`define CPBA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same clock as the antecedent.
`define CPBA_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

### hdl/cpba_pkg.sv
// ============================================================================
// Contiguous page bitmap allocator: package
// Command, status and register codes plus fixed field widths.
// ============================================================================
package cpba_pkg;

    // Fixed field widths.
    localparam int PAGE_W    = 12;
    localparam int TOT_W     = 13;
    localparam int LFSR_W    = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // Largest page total the 13-bit register can express.
    localparam int MAX_TOTAL = 8191;

    // Galois feedback taps of the skip-ahead generator.
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

    typedef logic [1:0]           t_cmd;
    typedef logic [1:0]           t_status;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cmd CMD_MARK_USED = 2'd0;
    localparam t_cmd CMD_MARK_FREE = 2'd1;
    localparam t_cmd CMD_FIND      = 2'd2;
    localparam t_cmd CMD_TEST      = 2'd3;

    localparam t_status ST_OK     = 2'd0;
    localparam t_status ST_NO_RUN = 2'd1;
    localparam t_status ST_ERROR  = 2'd2;

    localparam t_cfg_idx CFG_PAGES = 1'b0;
    localparam t_cfg_idx CFG_SEED  = 1'b1;

    // One step of the skip-ahead generator.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] sh;
        sh = s >> 1;
        return s[0] ? (sh ^ LFSR_TAPS) : sh;
    endfunction

endpackage

### hdl/cpba_ram.sv
// ============================================================================
// Contiguous page bitmap allocator: generic RAM
// One write port and one read port with registered read data.
// ============================================================================
module cpba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/cpba_jmod.sv
// ============================================================================
// Contiguous page bitmap allocator: skip distance unit
// Reduces a generator word modulo the jump span by reciprocal multiplication.
// ============================================================================
module cpba_jmod #(
    parameter int MAX_JUMP = 4096
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [cpba_pkg::LFSR_W-1:0]     i_value,
    output logic                            o_done,
    output logic [$clog2(MAX_JUMP)-1:0]     o_rem
);
    import cpba_pkg::*;

    localparam int JW = $clog2(MAX_JUMP);
    // Scaled reciprocal of the span, rounded up; the quotient is exact for
    // every 16-bit word when the product is shifted down by 32 bits.
    localparam int     RW    = 2 * LFSR_W + 1;
    localparam int     PW    = LFSR_W + RW;
    localparam longint RECIP = (longint'(1) << (2 * LFSR_W)) / longint'(MAX_JUMP) + 1;

    logic              r_ph1;
    logic              r_ph2;
    logic              r_done;
    logic [LFSR_W-1:0] r_val;
    logic [LFSR_W-1:0] r_quo;
    logic [LFSR_W-1:0] r_rem;
    logic [PW-1:0]     prod;
    logic [RW-1:0]     back;

    // Quotient estimate and its multiple of the span.
    always_comb begin
        prod = PW'(r_val) * PW'(RECIP);
        back = RW'(r_quo) * RW'(MAX_JUMP);
    end

    // Two stages: quotient first, then the remainder left over.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1  <= 1'b0;
            r_ph2  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph1  <= i_start;
            r_ph2  <= r_ph1;
            r_done <= r_ph2;
        end
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_ph1) begin
            r_quo <= prod[2*LFSR_W +: LFSR_W];
        end
        if (r_ph2) begin
            r_rem <= r_val - back[LFSR_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem[JW-1:0];

endmodule

### hdl/contiguous_page_bitmap_allocator.sv
// ============================================================================
// Contiguous page bitmap allocator
// Used/free page bitmap with range marking, page test and next-fit search.
// ============================================================================
// Usage: present a command word (i_cmd, i_start_page, i_page_count) with
// i_start; it is taken at a clock edge where o_busy is low. Exactly one
// result word follows, shown for one cycle with o_valid, and o_busy drops
// in that same cycle, so the next command may be issued right then.
// The receiver cannot stall; results must be captured when o_valid is high.
// A test reads one page; a rejected command finishes without reading the
// bitmap. A mark first reads and checks each page of the range, stopping at
// the first page in the wrong state, then writes the new state page by page.
// A find reads one page at a time and waits on the distance unit at each
// skip-ahead; the bitmap RAM's single registered read port, used once per
// page, sets the scan pace.
// Configuration words (i_cfg_valid, i_cfg_addr, i_cfg_data) are always
// accepted and must be sent only while the block is idle.
// After reset the bitmap RAM is cleared one page per cycle; o_busy stays
// high during that pass.
// ============================================================================
module contiguous_page_bitmap_allocator #(
    parameter int MAX_PAGES      = 4096,
    parameter int MAX_NEAR_TRIES = 65536,
    parameter int MAX_JUMP       = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  cpba_pkg::t_cmd                i_cmd,
    input  logic [cpba_pkg::PAGE_W-1:0]   i_start_page,
    input  logic [cpba_pkg::TOT_W-1:0]    i_page_count,
    output logic                          o_valid,
    output cpba_pkg::t_status             o_status,
    output logic [cpba_pkg::PAGE_W-1:0]   o_found_page,
    output logic                          o_page_is_free,
    output logic [cpba_pkg::TOT_W-1:0]    o_used_total,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  cpba_pkg::t_cfg_idx            i_cfg_addr,
    input  logic [cpba_pkg::CFG_W-1:0]    i_cfg_data
);
    import cpba_pkg::*;

    localparam int AW        = $clog2(MAX_PAGES);
    localparam int JW        = $clog2(MAX_JUMP);
    localparam int OW        = $clog2(MAX_PAGES + 3 * (MAX_TOTAL + 1) + MAX_JUMP);
    localparam int NW        = $clog2(MAX_NEAR_TRIES + 1);
    localparam int JUMP_Q    = MAX_JUMP / 4;
    localparam int SW        = $clog2(JUMP_Q + 1);
    localparam int TOTAL_RST = (MAX_PAGES < 4096) ? MAX_PAGES : 4096;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SETUP,
        S_RD,
        S_EV,
        S_JMP,
        S_WR
    } t_state;

    t_state            r_state, n_state;
    logic              r_busy, n_busy;
    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic [PAGE_W-1:0] r_found, n_found;
    logic              r_free, n_free;
    t_cmd              r_cmd, n_cmd;
    logic [PAGE_W-1:0] r_first, n_first;
    logic [TOT_W-1:0]  r_count, n_count;
    logic [OW-1:0]     r_sum, n_sum;
    logic [OW-1:0]     r_offset, n_offset;
    logic [TOT_W-1:0]  r_here, n_here;
    logic              r_wz, n_wz;
    logic [TOT_W-1:0]  r_run, n_run;
    logic [SW-1:0]     r_since, n_since;
    logic [NW-1:0]     r_near, n_near;
    logic [TOT_W-1:0]  r_nsp, n_nsp;
    logic [TOT_W-1:0]  r_used, n_used;
    logic [LFSR_W-1:0] r_lfsr, n_lfsr;
    logic [TOT_W-1:0]  r_total, n_total;

    logic              mark_used;
    logic [TOT_W:0]    mark_end;
    logic [OW-1:0]     total_w;
    logic [OW-1:0]     here_full;
    logic [TOT_W-1:0]  here_c;
    logic [TOT_W-1:0]  run_b;
    logic [TOT_W-1:0]  run_n;
    logic [SW-1:0]     since_n;
    logic [TOT_W-1:0]  cfg_pages;
    logic [TOT_W-1:0]  cfg_total;
    logic [LFSR_W-1:0] lfsr_nx;

    logic              ram_we;
    logic              ram_wdata;
    logic [0:0]        ram_q;
    logic              mod_start;
    logic              mod_done;
    logic [JW-1:0]     mod_rem;

    // Shared datapath terms.
    always_comb begin
        mark_used = (r_cmd == CMD_MARK_USED);
        mark_end  = (TOT_W+1)'(r_first) + (TOT_W+1)'(r_count);
        total_w   = OW'(r_total);
        here_full = (r_sum >= total_w) ? r_sum - total_w : r_sum;
        here_c    = TOT_W'(here_full);
        run_b     = r_wz ? '0 : r_run;
        run_n     = ram_q[0] ? '0 : run_b + 1'b1;
        since_n   = (r_since >= SW'(JUMP_Q)) ? r_since : r_since + 1'b1;
        lfsr_nx   = lfsr_step(r_lfsr);
        cfg_pages = i_cfg_data[TOT_W-1:0];
        if (cfg_pages == '0) begin
            cfg_total = TOT_W'(1);
        end else if (32'(cfg_pages) > 32'(MAX_PAGES)) begin
            cfg_total = TOT_W'(MAX_PAGES);
        end else begin
            cfg_total = cfg_pages;
        end
    end

    // Bitmap storage: one bit per page, 1 means used.
    cpba_ram #(
        .WIDTH (1),
        .DEPTH (MAX_PAGES)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_sum)),
        .i_wdata (ram_wdata),
        .i_raddr (AW'(here_c)),
        .o_rdata (ram_q)
    );

    // Skip distance reduction.
    cpba_jmod #(
        .MAX_JUMP (MAX_JUMP)
    ) u_jmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_value (lfsr_nx),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    // Sequencer next state.
    always_comb begin
        n_state   = r_state;
        n_busy    = r_busy;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_found   = r_found;
        n_free    = r_free;
        n_cmd     = r_cmd;
        n_first   = r_first;
        n_count   = r_count;
        n_sum     = r_sum;
        n_offset  = r_offset;
        n_here    = r_here;
        n_wz      = r_wz;
        n_run     = r_run;
        n_since   = r_since;
        n_near    = r_near;
        n_nsp     = r_nsp;
        n_used    = r_used;
        n_lfsr    = r_lfsr;
        n_total   = r_total;
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        mod_start = 1'b0;

        case (r_state)
            S_CLR: begin
                // Clear the bitmap one page per cycle after reset.
                ram_we = 1'b1;
                n_sum  = r_sum + 1'b1;
                if (r_sum == OW'(MAX_PAGES - 1)) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_cmd   = i_cmd;
                    n_first = i_start_page;
                    n_count = i_page_count;
                    n_busy  = 1'b1;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                // Default result word for an early finish.
                n_found  = '0;
                n_free   = 1'b0;
                n_status = ST_ERROR;
                n_offset = '0;
                case (r_cmd)
                    CMD_MARK_USED, CMD_MARK_FREE: begin
                        if (r_count == '0 || mark_end > (TOT_W+1)'(r_total)) begin
                            n_valid = 1'b1;
                            n_busy  = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            n_sum   = OW'(r_first);
                            n_state = S_RD;
                        end
                    end
                    CMD_FIND: begin
                        if (r_count == '0) begin
                            n_valid = 1'b1;
                            n_busy  = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            // Start point returns to page 0 after many searches.
                            if (r_near >= NW'(MAX_NEAR_TRIES)) begin
                                n_near = NW'(1);
                                n_nsp  = '0;
                                n_sum  = '0;
                            end else begin
                                n_near = r_near + 1'b1;
                                n_sum  = (r_nsp >= r_total) ? '0 : OW'(r_nsp);
                            end
                            n_run   = '0;
                            n_since = '0;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        if (TOT_W'(r_first) >= r_total) begin
                            n_valid = 1'b1;
                            n_busy  = 1'b0;
                            n_state = S_IDLE;
                        end else begin
                            n_sum   = OW'(r_first);
                            n_state = S_RD;
                        end
                    end
                endcase
            end
            S_RD: begin
                // Page read is issued here; a scan past the total fails.
                if (r_cmd == CMD_FIND && r_offset >= total_w) begin
                    n_status = ST_NO_RUN;
                    n_valid  = 1'b1;
                    n_busy   = 1'b0;
                    n_state  = S_IDLE;
                end else begin
                    n_here  = here_c;
                    n_wz    = (r_sum == total_w);
                    n_state = S_EV;
                end
            end
            S_EV: begin
                case (r_cmd)
                    CMD_MARK_USED, CMD_MARK_FREE: begin
                        if (ram_q[0] == mark_used) begin
                            n_status = ST_ERROR;
                            n_valid  = 1'b1;
                            n_busy   = 1'b0;
                            n_state  = S_IDLE;
                        end else if (r_offset + 1'b1 == OW'(r_count)) begin
                            n_sum    = OW'(r_first);
                            n_offset = '0;
                            n_state  = S_WR;
                        end else begin
                            n_sum    = r_sum + 1'b1;
                            n_offset = r_offset + 1'b1;
                            n_state  = S_RD;
                        end
                    end
                    CMD_FIND: begin
                        if (!ram_q[0] && run_n == r_count) begin
                            n_found  = PAGE_W'(r_here - run_b);
                            n_nsp    = r_here + 1'b1;
                            n_status = ST_OK;
                            n_valid  = 1'b1;
                            n_busy   = 1'b0;
                            n_state  = S_IDLE;
                        end else begin
                            n_run = run_n;
                            if (run_n == '0 && since_n >= SW'(JUMP_Q)) begin
                                // Skip ahead by a pseudo-random distance.
                                n_lfsr    = lfsr_nx;
                                mod_start = 1'b1;
                                n_since   = '0;
                                n_state   = S_JMP;
                            end else begin
                                n_since  = since_n;
                                n_sum    = r_sum + 1'b1;
                                n_offset = r_offset + 1'b1;
                                n_state  = S_RD;
                            end
                        end
                    end
                    default: begin
                        n_status = ST_OK;
                        n_free   = ~ram_q[0];
                        n_valid  = 1'b1;
                        n_busy   = 1'b0;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_JMP: begin
                if (mod_done) begin
                    n_sum    = r_sum + OW'(mod_rem);
                    n_offset = r_offset + OW'(mod_rem);
                    n_state  = S_RD;
                end
            end
            S_WR: begin
                // Range checked clean: write the new state page by page.
                ram_we    = 1'b1;
                ram_wdata = mark_used;
                n_sum     = r_sum + 1'b1;
                n_offset  = r_offset + 1'b1;
                if (r_offset + 1'b1 == OW'(r_count)) begin
                    n_used   = mark_used ? r_used + r_count : r_used - r_count;
                    n_status = ST_OK;
                    n_valid  = 1'b1;
                    n_busy   = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase

        // Configuration words.
        if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_PAGES: n_total = cfg_total;
                CFG_SEED:  n_lfsr  = (i_cfg_data == '0) ? LFSR_W'(1) : i_cfg_data;
                default:   n_total = r_total;
            endcase
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_busy  <= 1'b1;
            r_valid <= 1'b0;
            r_sum   <= '0;
            r_near  <= '0;
            r_nsp   <= '0;
            r_used  <= '0;
            r_lfsr  <= LFSR_W'(1);
            r_total <= TOT_W'(TOTAL_RST);
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
            r_sum   <= n_sum;
            r_near  <= n_near;
            r_nsp   <= n_nsp;
            r_used  <= n_used;
            r_lfsr  <= n_lfsr;
            r_total <= n_total;
        end
        r_status <= n_status;
        r_found  <= n_found;
        r_free   <= n_free;
        r_cmd    <= n_cmd;
        r_first  <= n_first;
        r_count  <= n_count;
        r_offset <= n_offset;
        r_here   <= n_here;
        r_wz     <= n_wz;
        r_run    <= n_run;
        r_since  <= n_since;
    end

    assign o_busy         = r_busy;
    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_found_page   = r_found;
    assign o_page_is_free = r_free;
    assign o_used_total   = r_used;
    assign o_cfg_ready    = 1'b1;

endmodule

### hdl/cpba_checker.sv
// ============================================================================
// Contiguous page bitmap allocator: port checker
// Concurrent checks on the command and result words seen at the ports.
// ============================================================================
`include "contiguous_page_bitmap_allocator_macros.svh"

module cpba_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_valid,
    input cpba_pkg::t_status             o_status,
    input logic [cpba_pkg::PAGE_W-1:0]   o_found_page,
    input logic                          o_page_is_free
);
    import cpba_pkg::*;

    // An accepted command keeps the block busy in the next cycle.
    `CPBA_ASSERT_NEXT(a_accept_busy, i_start && !o_busy, o_busy, "busy not raised after accept")

    // A result word is shown only once the block is free again.
    `CPBA_ASSERT_SAME(a_valid_idle, o_valid, !o_busy, "result shown while busy")

    // Each command yields a single one-cycle result word.
    `CPBA_ASSERT_NEXT(a_valid_pulse, o_valid, !o_valid, "result strobe longer than one cycle")

    // A failed command reports no page and no free flag.
    `CPBA_ASSERT_SAME(a_fail_clean, o_valid && o_status != ST_OK, o_found_page == '0 && !o_page_is_free, "failed command carries payload")

endmodule

bind contiguous_page_bitmap_allocator cpba_checker u_cpba_checker (.*);

### tb/page_alloc_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Page allocator checker
// Watches the command, result and register channels of the page allocator.
// It keeps its own page bitmap, search pointer and skip-ahead generator, works
// out the result word of every accepted command, and compares each result
// word field by field with the oldest prediction.
// ============================================================================
module page_alloc_checker #(
    parameter int MAX_PAGES      = 4096,
    parameter int MAX_NEAR_TRIES = 65536,
    parameter int MAX_JUMP       = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  cpba_pkg::t_cmd                i_cmd,
    input  logic [cpba_pkg::PAGE_W-1:0]   i_start_page,
    input  logic [cpba_pkg::TOT_W-1:0]    i_page_count,
    input  logic                          i_valid,
    input  cpba_pkg::t_status             i_status,
    input  logic [cpba_pkg::PAGE_W-1:0]   i_found_page,
    input  logic                          i_page_is_free,
    input  logic [cpba_pkg::TOT_W-1:0]    i_used_total,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  cpba_pkg::t_cfg_idx            i_cfg_addr,
    input  logic [cpba_pkg::CFG_W-1:0]    i_cfg_data,
    output int                            o_fails,
    output int                            o_pending
);
    import cpba_pkg::*;

    typedef struct packed {
        t_status           status;
        logic [PAGE_W-1:0] found;
        logic              is_free;
        logic [TOT_W-1:0]  used;
    } t_reply;

    // Shadow copy of the allocator state.
    bit                page_used [MAX_PAGES];
    logic [TOT_W-1:0]  pages_reg;
    int unsigned       seek_from;
    int unsigned       find_count;
    int unsigned       used_pages_n;
    logic [LFSR_W-1:0] skip_lfsr;

    t_reply            reply_q [$];
    int                fail_n = 0;

    initial begin
        o_fails   = 0;
        o_pending = 0;
    end

    // Register values of 0 and above the bitmap size are clamped.
    function automatic int unsigned page_limit();
        if (pages_reg == '0) return 1;
        if (pages_reg > MAX_PAGES) return MAX_PAGES;
        return pages_reg;
    endfunction

    function automatic bit page_open(input int unsigned pg);
        return (pg < MAX_PAGES) && !page_used[pg];
    endfunction

    // A run is marked only when every page in it is in the opposite state.
    function automatic t_status mark_pages(input int unsigned first,
                                           input int unsigned count,
                                           input bit          used);
        int unsigned total;
        total = page_limit();
        if (count == 0 || first + count > total) return ST_ERROR;
        for (int unsigned i = 0; i < count; i++)
            if (page_open(first + i) != used) return ST_ERROR;
        for (int unsigned i = 0; i < count; i++)
            page_used[first + i] = used;
        if (used) used_pages_n += count;
        else used_pages_n -= count;
        return ST_OK;
    endfunction

    // Next-fit scan with wrap, dropping runs that cross the wrap, and a
    // pseudo-random skip after a long stretch with no free run.
    function automatic t_status seek_free_run(input int unsigned n,
                                              output int unsigned first);
        int unsigned total;
        int unsigned base;
        int unsigned offset;
        int unsigned since_skip;
        int unsigned run;
        int unsigned here;
        total      = page_limit();
        first      = 0;
        offset     = 0;
        since_skip = 0;
        run        = 0;
        if (find_count >= MAX_NEAR_TRIES) begin
            find_count = 0;
            seek_from  = 0;
        end
        find_count++;
        base = (seek_from >= total) ? 0 : seek_from;
        while (offset < total) begin
            here = base + offset;
            if (here >= total) begin
                here -= total;
                if (here == 0) run = 0;
            end
            if (page_open(here)) begin
                run++;
                if (run == n) begin
                    first     = here - (n - 1);
                    seek_from = here + 1;
                    return ST_OK;
                end
            end else begin
                run = 0;
            end
            since_skip++;
            if (run == 0 && since_skip >= MAX_JUMP / 4) begin
                if (skip_lfsr[0]) skip_lfsr = (skip_lfsr >> 1) ^ LFSR_TAPS;
                else skip_lfsr = skip_lfsr >> 1;
                offset += int'(skip_lfsr) % MAX_JUMP;
                since_skip = 0;
            end else begin
                offset++;
            end
        end
        return ST_NO_RUN;
    endfunction

    function automatic t_reply predict_reply(input t_cmd              c,
                                             input logic [PAGE_W-1:0] pg,
                                             input logic [TOT_W-1:0]  n);
        t_reply      r;
        t_status     st;
        int unsigned first;
        r = '0;
        case (c)
            CMD_MARK_USED: r.status = mark_pages(pg, n, 1'b1);
            CMD_MARK_FREE: r.status = mark_pages(pg, n, 1'b0);
            CMD_FIND: begin
                if (n == '0) begin
                    r.status = ST_ERROR;
                end else begin
                    st       = seek_free_run(n, first);
                    r.status = st;
                    if (st == ST_OK) r.found = first[PAGE_W-1:0];
                end
            end
            CMD_TEST: begin
                if (pg >= page_limit()) r.status = ST_ERROR;
                else r.is_free = page_open(pg);
            end
            default: r.status = ST_ERROR;
        endcase
        r.used = used_pages_n[TOT_W-1:0];
        return r;
    endfunction

    function automatic void clear_shadow();
        for (int i = 0; i < MAX_PAGES; i++) page_used[i] = 1'b0;
        pages_reg    = TOT_W'(4096);
        seek_from    = 0;
        find_count   = 0;
        used_pages_n = 0;
        skip_lfsr    = LFSR_W'(1);
    endfunction

    // A seed write also reloads the generator; a zero seed loads 1.
    function automatic void write_register(input t_cfg_idx a, input logic [CFG_W-1:0] d);
        if (a == CFG_PAGES) pages_reg = d[TOT_W-1:0];
        else if (a == CFG_SEED) skip_lfsr = (d == '0) ? LFSR_W'(1) : d;
    endfunction

    task automatic check_reply(input t_reply want);
        if (i_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, i_status);
            fail_n++;
        end
        if (i_found_page !== want.found) begin
            $error("found_page: expected %0d, got %0d", want.found, i_found_page);
            fail_n++;
        end
        if (i_page_is_free !== want.is_free) begin
            $error("page_is_free: expected %0d, got %0d", want.is_free, i_page_is_free);
            fail_n++;
        end
        if (i_used_total !== want.used) begin
            $error("used_total: expected %0d, got %0d", want.used, i_used_total);
            fail_n++;
        end
    endtask

    // Results are checked before a command taken on the same edge is predicted.
    always @(posedge i_clk) begin : watch
        t_reply want;
        if (!i_rst_n) begin
            clear_shadow();
            reply_q.delete();
        end else begin
            if (i_valid === 1'b1) begin
                if (reply_q.size() == 0) begin
                    $error("result word with no command outstanding");
                    fail_n++;
                end else begin
                    want = reply_q.pop_front();
                    check_reply(want);
                end
            end
            if (i_cfg_valid && i_cfg_ready) write_register(i_cfg_addr, i_cfg_data);
            if (i_start && !i_busy)
                reply_q.push_back(predict_reply(i_cmd, i_start_page, i_page_count));
        end
        o_pending <= reply_q.size();
        o_fails   <= fail_n;
    end

endmodule

### tb/tb_contiguous_page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// Contiguous page bitmap allocator testbench
// Drives directed command words over the edge cases of marking, testing and
// searching, then random phases of allocate/free traffic with noise under
// several page totals and seeds. A separate checker predicts and compares
// every result word; this module only makes stimulus and gives the verdict.
// ============================================================================
module tb_contiguous_page_bitmap_allocator;
    import cpba_pkg::*;

    localparam int MAX_PAGES      = 4096;
    localparam int MAX_NEAR_TRIES = 65536;
    localparam int MAX_JUMP       = 4096;
    localparam int QUIET_LIMIT    = 200000;
    localparam int PHASE_WORDS    = 165;
    localparam int TAIL_CYCLES    = 20;
    localparam int NUM_PHASES     = 9;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_start      = 1'b0;
    logic                o_busy;
    t_cmd                i_cmd        = CMD_TEST;
    logic [PAGE_W-1:0]   i_start_page = '0;
    logic [TOT_W-1:0]    i_page_count = '0;
    logic                o_valid;
    t_status             o_status;
    logic [PAGE_W-1:0]   o_found_page;
    logic                o_page_is_free;
    logic [TOT_W-1:0]    o_used_total;
    logic                i_cfg_valid  = 1'b0;
    logic                o_cfg_ready;
    t_cfg_idx            i_cfg_addr   = CFG_PAGES;
    logic [CFG_W-1:0]    i_cfg_data   = '0;

    int                  fails;
    int                  pending;
    int unsigned         words_sent   = 0;
    int unsigned         quiet_cycles = 0;
    int unsigned         gap_pct      = 0;
    int unsigned         run_first [$];
    int unsigned         run_len [$];
    int unsigned         phase_pages [NUM_PHASES] = '{64, 4096, 0, 300, 8191, 16, 1000, 1, 128};

    always #2 i_clk = ~i_clk;

    contiguous_page_bitmap_allocator #(
        .MAX_PAGES      (MAX_PAGES),
        .MAX_NEAR_TRIES (MAX_NEAR_TRIES),
        .MAX_JUMP       (MAX_JUMP)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_start_page   (i_start_page),
        .i_page_count   (i_page_count),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_found_page   (o_found_page),
        .o_page_is_free (o_page_is_free),
        .o_used_total   (o_used_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    page_alloc_checker #(
        .MAX_PAGES      (MAX_PAGES),
        .MAX_NEAR_TRIES (MAX_NEAR_TRIES),
        .MAX_JUMP       (MAX_JUMP)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_start_page   (i_start_page),
        .i_page_count   (i_page_count),
        .i_valid        (o_valid),
        .i_status       (o_status),
        .i_found_page   (o_found_page),
        .i_page_is_free (o_page_is_free),
        .i_used_total   (o_used_total),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .o_fails        (fails),
        .o_pending      (pending)
    );

    // Watchdog: ends the run after a long stretch with no handshake at all.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid === 1'b1 || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Mostly pages inside the current total, now and then any page at all.
    function automatic int unsigned pick_page(input int unsigned eff);
        return ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(eff - 1);
    endfunction

    task automatic go_idle();
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    // Random sender gap, then one command word held until it is taken.
    task automatic put_word(input t_cmd c, input int unsigned pg, input int unsigned n);
        if ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            while ($urandom_range(99) < gap_pct) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_start      <= 1'b1;
        i_cmd        <= c;
        i_start_page <= pg[PAGE_W-1:0];
        i_page_count <= n[TOT_W-1:0];
        do @(posedge i_clk); while (o_busy);
        words_sent++;
    endtask

    task automatic take_result(output t_status st, output logic [PAGE_W-1:0] fp);
        do @(posedge i_clk); while (o_valid !== 1'b1);
        st = o_status;
        fp = o_found_page;
    endtask

    // Block idle: no command held, every prediction answered, not busy.
    task automatic wait_quiet();
        go_idle();
        do @(posedge i_clk); while (pending != 0 || o_busy);
    endtask

    task automatic write_reg(input t_cfg_idx a, input logic [CFG_W-1:0] d);
        wait_quiet();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One random step: mostly find-then-claim and release of claimed runs,
    // the rest tests, random marks, odd-sized finds and zero counts.
    task automatic random_word(input int unsigned eff);
        int unsigned       pick;
        int unsigned       n;
        int unsigned       idx;
        t_status           st;
        logic [PAGE_W-1:0] fp;
        pick = $urandom_range(99);
        if (pick < 35) begin
            if ($urandom_range(4) == 0) n = $urandom_range(1, (eff < 64) ? eff : 64);
            else n = $urandom_range(1, 8);
            put_word(CMD_FIND, pick_page(eff), n);
            go_idle();
            take_result(st, fp);
            if (st == ST_OK) begin
                put_word(CMD_MARK_USED, fp, n);
                run_first.push_back(fp);
                run_len.push_back(n);
            end
        end else if (pick < 55 && run_first.size() > 0) begin
            idx = $urandom_range(run_first.size() - 1);
            put_word(CMD_MARK_FREE, run_first[idx], run_len[idx]);
            run_first.delete(idx);
            run_len.delete(idx);
        end else if (pick < 70) begin
            put_word(CMD_TEST, pick_page(eff), $urandom_range(8191));
        end else if (pick < 82) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(1, 8191) : $urandom_range(1, 16);
            put_word($urandom_range(1) ? CMD_MARK_USED : CMD_MARK_FREE, pick_page(eff), n);
        end else if (pick < 94) begin
            case ($urandom_range(19))
                0:       n = $urandom_range(1, 8191);
                1, 2:    n = $urandom_range(1, eff);
                default: n = $urandom_range(1, 16);
            endcase
            put_word(CMD_FIND, $urandom_range(4095), n);
        end else begin
            put_word(t_cmd'($urandom_range(3)), $urandom_range(4095), 0);
        end
    endtask

    initial begin : stimulus
        int unsigned pages;
        int unsigned seed;
        int unsigned eff;
        int unsigned target;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings: 4096 pages, seed 1.
        gap_pct = 15;
        put_word(CMD_TEST, 0, 1);
        put_word(CMD_TEST, 4095, 8191);
        put_word(CMD_MARK_USED, 0, 0);
        put_word(CMD_FIND, 0, 0);
        put_word(CMD_MARK_USED, 0, 8);
        put_word(CMD_MARK_USED, 4, 2);
        put_word(CMD_MARK_FREE, 8, 1);
        put_word(CMD_MARK_USED, 4095, 1);
        put_word(CMD_MARK_USED, 4095, 2);
        put_word(CMD_FIND, 0, 5);
        put_word(CMD_FIND, 4095, 4096);
        put_word(CMD_FIND, 0, 8191);
        put_word(CMD_MARK_FREE, 0, 8);
        put_word(CMD_MARK_USED, 0, 4096);
        put_word(CMD_MARK_FREE, 4095, 1);
        // Full map: the search runs through skips and fails.
        put_word(CMD_MARK_USED, 0, 4096);
        put_word(CMD_TEST, 2048, 1);
        put_word(CMD_FIND, 0, 1);
        put_word(CMD_MARK_FREE, 0, 4096);
        put_word(CMD_MARK_FREE, 4095, 8191);

        // A total of 0 acts as one page; the remembered start is now stale.
        write_reg(CFG_PAGES, '0);
        put_word(CMD_TEST, 0, 1);
        put_word(CMD_TEST, 1, 1);
        put_word(CMD_FIND, 0, 1);
        put_word(CMD_FIND, 0, 2);
        put_word(CMD_MARK_USED, 0, 1);

        // Upper data bits are dropped, leaving one page above the bitmap.
        write_reg(CFG_PAGES, 16'hF001);
        put_word(CMD_TEST, 4095, 1);
        put_word(CMD_MARK_USED, 4095, 2);

        // Random phases: sender gaps light, then heavy, then none.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            pages = phase_pages[ph];
            case (ph)
                1:       seed = 65535;
                2:       seed = 0;
                4:       seed = 1;
                default: seed = $urandom_range(1, 65535);
            endcase
            write_reg(CFG_PAGES, pages[CFG_W-1:0]);
            write_reg(CFG_SEED, seed[CFG_W-1:0]);
            gap_pct = (ph < 3) ? 15 : (ph < 6) ? 88 : 0;
            eff     = (pages == 0) ? 1 : (pages > MAX_PAGES) ? MAX_PAGES : pages;
            run_first.delete();
            run_len.delete();
            target = words_sent + PHASE_WORDS;
            while (words_sent < target) random_word(eff);
        end

        wait_quiet();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fails == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/cpba_pkg.sv
hdl/cpba_ram.sv
hdl/cpba_jmod.sv
hdl/contiguous_page_bitmap_allocator.sv
hdl/cpba_checker.sv
tb/page_alloc_checker.sv
tb/tb_contiguous_page_bitmap_allocator.sv
